// File: rtl/imsv_pkg.sv
// ----------------------------------------------------------------------------
// imsv_pkg
// Shared types, constants and small lookup functions for the slip-control
// volts-per-hertz step core.
// ----------------------------------------------------------------------------
`default_nettype none

package imsv_pkg;

  localparam int HIST_DEPTH     = 256;
  localparam int HIST_AW        = $clog2(HIST_DEPTH);
  localparam int ANGLE_SHIFT    = 19;
  localparam int SINE_FRAC_BITS = 15;
  localparam int SINE_W         = SINE_FRAC_BITS + 1;
  localparam int IDX_W          = 32 - ANGLE_SHIFT;
  localparam int QTR_W          = IDX_W - 2;
  localparam int QTR_SIZE       = 1 << QTR_W;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);
  localparam int MUL_W          = 33;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int DPROD_W        = 12 + SINE_W;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [11:0] CENTER      = 12'd2047;
  localparam logic [31:0] PHASE_B_OFS = 32'h5555_5555;
  localparam logic [31:0] PHASE_C_OFS = 32'hAAAA_AAAB;

  localparam logic signed [33:0] SINE_RND = 34'(64'd1 << (29 - SINE_FRAC_BITS));
  localparam logic [SINE_FRAC_BITS-1:0] SINE_TOP = {SINE_FRAC_BITS{1'b1}};

  localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);

  typedef enum logic [2:0] {
    CFG_THROTTLE_MIN    = 3'd0,
    CFG_THROTTLE_MAX    = 3'd1,
    CFG_SLIP_GAIN       = 3'd2,
    CFG_ENCODER_GAIN    = 3'd3,
    CFG_VOLT_GAIN       = 3'd4,
    CFG_VOLTAGE_LIMIT   = 3'd5,
    CFG_OVERSPEED_LIMIT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] throttle_min;
    logic [11:0] throttle_max;
    logic [31:0] slip_gain;
    logic [23:0] encoder_gain;
    logic [23:0] volt_gain;
    logic [10:0] voltage_limit;
    logic [14:0] overspeed_limit;
  } cfg_t;

  typedef struct packed {
    logic [15:0] diff;
    logic [15:0] braked;
    logic [11:0] off;
    logic        fault;
    logic        oe;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLIP,
    ST_ENC,
    ST_INC,
    ST_VOLT,
    ST_AMP,
    ST_SX,
    ST_SX2,
    ST_SQ,
    ST_TM,
    ST_DQ,
    ST_DC,
    ST_DF,
    ST_FIN,
    ST_DT,
    ST_OUT
  } back_state_t;

  function automatic logic [6:0] div_k(input logic [1:0] step);
    case (step)
      2'd0:    div_k = 7'd6;
      2'd1:    div_k = 7'd20;
      2'd2:    div_k = 7'd42;
      default: div_k = 7'd72;
    endcase
  endfunction

  function automatic logic [31:0] div_recip(input logic [1:0] step);
    case (step)
      2'd0:    div_recip = RECIP_6;
      2'd1:    div_recip = RECIP_20;
      2'd2:    div_recip = RECIP_42;
      default: div_recip = RECIP_72;
    endcase
  endfunction

  function automatic logic [31:0] phase_ofs(input logic [1:0] phase);
    case (phase)
      2'd0:    phase_ofs = 32'd0;
      2'd1:    phase_ofs = PHASE_B_OFS;
      default: phase_ofs = PHASE_C_OFS;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/imsv_front.sv
// ----------------------------------------------------------------------------
// imsv_front
// Accepts requests, looks up the encoder history ring, forms speed, braked
// speed, throttle offset and the sticky overspeed fault, and pushes a record.
// ----------------------------------------------------------------------------
`default_nettype none

module imsv_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire imsv_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [15:0]    in_encoder_count,
  input  wire logic [11:0]    in_throttle_adc,
  input  wire logic           in_forward,
  input  wire logic           in_start_req,
  output logic                q_push,
  input  wire logic           q_ready,
  output imsv_pkg::rec_t      q_rec
);

  logic [15:0]                     hist_mem [imsv_pkg::HIST_DEPTH];
  logic [imsv_pkg::HIST_DEPTH-1:0] hist_vld_r;
  logic [imsv_pkg::HIST_AW-1:0]    pos_r;
  logic [imsv_pkg::HIST_AW-1:0]    wpos_r;
  logic                            s1_v_r;
  logic                            fault_r;
  logic [15:0]                     rd_data_r;
  logic                            rd_vld_r;
  logic [15:0]                     count_r;
  logic [11:0]                     adc_r;
  logic                            fwd_r;
  logic                            start_r;

  logic        accept;
  logic [15:0] old_count;
  logic [15:0] diff;
  logic [15:0] braked;
  logic [16:0] d17;
  logic [16:0] lim17;
  logic        over;
  logic        fault_new;
  logic [11:0] thr_lo;
  logic [11:0] thr_hi;
  logic [11:0] off;

  assign accept = in_valid && in_ready;
  assign in_ready = !s1_v_r || q_ready;
  assign q_push = s1_v_r && q_ready;

  assign old_count = rd_vld_r ? rd_data_r : 16'd0;
  assign diff = count_r - old_count;
  assign braked = diff[15] ? diff + 16'd1 : ((diff != 16'd0) ? diff - 16'd1 : 16'd0);

  assign d17 = {diff[15], diff};
  assign lim17 = {2'b00, cfg.overspeed_limit};
  assign over = ($signed(d17) > $signed(lim17)) || ($signed(d17) < -$signed(lim17));
  assign fault_new = fault_r || over;

  assign thr_lo = (adc_r < cfg.throttle_min) ? cfg.throttle_min : adc_r;
  assign thr_hi = (thr_lo > cfg.throttle_max) ? cfg.throttle_max : thr_lo;
  assign off = (thr_hi >= cfg.throttle_min) ? thr_hi - cfg.throttle_min : 12'd0;

  always_comb begin
    q_rec.diff = diff;
    q_rec.braked = braked;
    q_rec.off = fwd_r ? off : 12'd0;
    q_rec.fault = fault_new;
    q_rec.oe = start_r && !fault_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      s1_v_r <= 1'b0;
      fault_r <= 1'b0;
      hist_vld_r <= '0;
    end else begin
      if (accept) begin
        pos_r <= (pos_r == imsv_pkg::HIST_AW'(imsv_pkg::HIST_DEPTH - 1)) ? '0 : pos_r + 1'b1;
        s1_v_r <= 1'b1;
      end else if (q_push) begin
        s1_v_r <= 1'b0;
      end
      if (q_push) begin
        fault_r <= fault_new;
        hist_vld_r[wpos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= hist_mem[pos_r];
      rd_vld_r <= hist_vld_r[pos_r];
      wpos_r <= pos_r;
      count_r <= in_encoder_count;
      adc_r <= in_throttle_adc;
      fwd_r <= in_forward;
      start_r <= in_start_req;
    end
    if (q_push) begin
      hist_mem[wpos_r] <= count_r;
    end
  end

endmodule

`default_nettype wire

// File: rtl/imsv_queue.sv
// ----------------------------------------------------------------------------
// imsv_queue
// Short record queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module imsv_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  output logic                push_ready,
  input  wire imsv_pkg::rec_t push_rec,
  output logic                pop_valid,
  input  wire logic           pop,
  output imsv_pkg::rec_t      pop_rec
);

  imsv_pkg::rec_t                q_mem [imsv_pkg::QUEUE_DEPTH];
  logic [imsv_pkg::QUEUE_AW-1:0] wr_ptr_r;
  logic [imsv_pkg::QUEUE_AW-1:0] rd_ptr_r;
  logic [imsv_pkg::QUEUE_AW:0]   count_r;

  assign push_ready = (count_r != (imsv_pkg::QUEUE_AW + 1)'(imsv_pkg::QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_rec = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == imsv_pkg::QUEUE_AW'(imsv_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == imsv_pkg::QUEUE_AW'(imsv_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// File: rtl/imsv_back.sv
// ----------------------------------------------------------------------------
// imsv_back
// Sequencer around one shared multiplier: slip, angle increment, amplitude,
// per-phase sine by series evaluation, duty cycles and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module imsv_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire imsv_pkg::cfg_t cfg,
  input  wire logic           q_valid,
  output logic                q_pop,
  input  wire imsv_pkg::rec_t q_rec,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [11:0]         out_duty_a,
  output logic [11:0]         out_duty_b,
  output logic [11:0]         out_duty_c,
  output logic signed [11:0]  out_amplitude,
  output logic signed [15:0]  out_speed_delta,
  output logic                out_output_enable,
  output logic                out_fault
);

  localparam int F = imsv_pkg::SINE_FRAC_BITS;

  imsv_pkg::back_state_t state_r, state_nxt;

  logic signed [imsv_pkg::MUL_W-1:0]  op_a;
  logic signed [imsv_pkg::MUL_W-1:0]  op_b;
  logic signed [imsv_pkg::PROD_W-1:0] prod_r;

  imsv_pkg::rec_t rec_r, rec_nxt;
  logic [31:0]         slip_r, slip_nxt;
  logic [31:0]         inc_r, inc_nxt;
  logic [31:0]         angle_r, angle_nxt;
  logic signed [11:0]  amp_r, amp_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic signed [33:0]  s_r, s_nxt;
  logic [31:0]         t_r, t_nxt;
  logic [31:0]         x2_r, x2_nxt;
  logic [31:0]         n_r, n_nxt;
  logic [31:0]         q0_r, q0_nxt;
  logic [1:0]          step_r, step_nxt;
  logic [11:0]         duty_a_r, duty_a_nxt;
  logic [11:0]         duty_b_r, duty_b_nxt;
  logic [11:0]         duty_c_r, duty_c_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_load;
  logic [11:0]         o_duty_a_r, o_duty_b_r, o_duty_c_r;
  logic signed [11:0]  o_amp_r;
  logic [15:0]         o_speed_r;
  logic                o_oe_r, o_fault_r;

  logic [31:0]                   inc_sum;
  logic [31:0]                   ang_sel;
  logic [imsv_pkg::IDX_W-1:0]    idx;
  logic [imsv_pkg::QTR_W:0]      rr;
  logic [30:0]                   x_w;
  logic [imsv_pkg::PROD_W-1:0]   pabs_a;
  logic [10:0]                   amag;
  logic signed [11:0]            amp_w;
  logic [6:0]                    k_w;
  logic [31:0]                   rem_w;
  logic [31:0]                   q_w;
  logic signed [33:0]            sround;
  logic [F+3:0]                  v_w;
  logic [F-1:0]                  sv_w;
  logic [imsv_pkg::SINE_W-1:0]   sin_w;
  logic [imsv_pkg::DPROD_W-1:0]  p_w;
  logic [imsv_pkg::DPROD_W-1:0]  pabs_p;
  logic [11:0]                   mag_w;
  logic [11:0]                   duty_w;

  assign inc_sum = prod_r[31:0] + slip_r;

  assign ang_sel = angle_r + imsv_pkg::phase_ofs(phase_r);
  assign idx = ang_sel[31:imsv_pkg::ANGLE_SHIFT];
  assign rr = idx[imsv_pkg::QTR_W] ?
              (imsv_pkg::QTR_W + 1)'(imsv_pkg::QTR_SIZE) - {1'b0, idx[imsv_pkg::QTR_W-1:0]} :
              {1'b0, idx[imsv_pkg::QTR_W-1:0]};
  assign x_w = prod_r[imsv_pkg::QTR_W +: 31];

  assign pabs_a = prod_r[imsv_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign amag = (pabs_a[63:32] > {21'd0, cfg.voltage_limit}) ?
                cfg.voltage_limit : pabs_a[42:32];
  assign amp_w = prod_r[imsv_pkg::PROD_W-1] ? -$signed({1'b0, amag}) : $signed({1'b0, amag});

  assign k_w = imsv_pkg::div_k(step_r);
  assign rem_w = n_r - prod_r[31:0];
  assign q_w = (rem_w >= {25'd0, k_w}) ? q0_r + 32'd1 : q0_r;

  assign sround = s_r + imsv_pkg::SINE_RND;
  assign v_w = sround[33:30-F];
  assign sv_w = s_r[33] ? '0 :
                ((v_w > (F + 4)'(imsv_pkg::SINE_TOP)) ? imsv_pkg::SINE_TOP : v_w[F-1:0]);
  assign sin_w = neg_r ? -{1'b0, sv_w} : {1'b0, sv_w};

  assign p_w = prod_r[imsv_pkg::DPROD_W-1:0];
  assign pabs_p = p_w[imsv_pkg::DPROD_W-1] ? -p_w : p_w;
  assign mag_w = 12'(pabs_p >> F);
  assign duty_w = p_w[imsv_pkg::DPROD_W-1] ? imsv_pkg::CENTER - mag_w :
                  imsv_pkg::CENTER + mag_w;

  always_comb begin
    state_nxt = state_r;
    rec_nxt = rec_r;
    slip_nxt = slip_r;
    inc_nxt = inc_r;
    angle_nxt = angle_r;
    amp_nxt = amp_r;
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    s_nxt = s_r;
    t_nxt = t_r;
    x2_nxt = x2_r;
    n_nxt = n_r;
    q0_nxt = q0_r;
    step_nxt = step_r;
    duty_a_nxt = duty_a_r;
    duty_b_nxt = duty_b_r;
    duty_c_nxt = duty_c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load = 1'b0;
    q_pop = 1'b0;
    op_a = '0;
    op_b = '0;
    case (state_r)
      imsv_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          rec_nxt = q_rec;
          state_nxt = imsv_pkg::ST_SLIP;
        end
      end
      imsv_pkg::ST_SLIP: begin
        op_a = {21'd0, rec_r.off};
        op_b = {1'b0, cfg.slip_gain};
        state_nxt = imsv_pkg::ST_ENC;
      end
      imsv_pkg::ST_ENC: begin
        slip_nxt = prod_r[47:16];
        op_a = {{17{rec_r.braked[15]}}, rec_r.braked};
        op_b = {9'd0, cfg.encoder_gain};
        state_nxt = imsv_pkg::ST_INC;
      end
      imsv_pkg::ST_INC: begin
        inc_nxt = inc_sum;
        angle_nxt = angle_r + inc_sum;
        state_nxt = imsv_pkg::ST_VOLT;
      end
      imsv_pkg::ST_VOLT: begin
        op_a = {inc_r[31], inc_r};
        op_b = {9'd0, cfg.volt_gain};
        state_nxt = imsv_pkg::ST_AMP;
      end
      imsv_pkg::ST_AMP: begin
        amp_nxt = amp_w;
        phase_nxt = 2'd0;
        state_nxt = imsv_pkg::ST_SX;
      end
      imsv_pkg::ST_SX: begin
        neg_nxt = idx[imsv_pkg::IDX_W-1];
        op_a = {{(imsv_pkg::MUL_W - imsv_pkg::QTR_W - 1){1'b0}}, rr};
        op_b = {2'b00, imsv_pkg::HALF_PI_Q30};
        state_nxt = imsv_pkg::ST_SX2;
      end
      imsv_pkg::ST_SX2: begin
        s_nxt = {3'b000, x_w};
        t_nxt = {1'b0, x_w};
        op_a = {2'b00, x_w};
        op_b = {2'b00, x_w};
        state_nxt = imsv_pkg::ST_SQ;
      end
      imsv_pkg::ST_SQ: begin
        x2_nxt = prod_r[61:30];
        step_nxt = 2'd0;
        state_nxt = imsv_pkg::ST_TM;
      end
      imsv_pkg::ST_TM: begin
        op_a = {1'b0, t_r};
        op_b = {1'b0, x2_r};
        state_nxt = imsv_pkg::ST_DQ;
      end
      imsv_pkg::ST_DQ: begin
        n_nxt = prod_r[61:30];
        op_a = {1'b0, prod_r[61:30]};
        op_b = {1'b0, imsv_pkg::div_recip(step_r)};
        state_nxt = imsv_pkg::ST_DC;
      end
      imsv_pkg::ST_DC: begin
        q0_nxt = prod_r[63:32];
        op_a = {1'b0, prod_r[63:32]};
        op_b = {26'd0, k_w};
        state_nxt = imsv_pkg::ST_DF;
      end
      imsv_pkg::ST_DF: begin
        t_nxt = q_w;
        s_nxt = step_r[0] ? s_r + $signed({2'b00, q_w}) : s_r - $signed({2'b00, q_w});
        if (step_r == 2'd3) begin
          state_nxt = imsv_pkg::ST_FIN;
        end else begin
          step_nxt = step_r + 2'd1;
          state_nxt = imsv_pkg::ST_TM;
        end
      end
      imsv_pkg::ST_FIN: begin
        op_a = {{(imsv_pkg::MUL_W - 12){amp_r[11]}}, amp_r};
        op_b = {{(imsv_pkg::MUL_W - imsv_pkg::SINE_W){sin_w[imsv_pkg::SINE_W-1]}}, sin_w};
        state_nxt = imsv_pkg::ST_DT;
      end
      imsv_pkg::ST_DT: begin
        case (phase_r)
          2'd0:    duty_a_nxt = duty_w;
          2'd1:    duty_b_nxt = duty_w;
          default: duty_c_nxt = duty_w;
        endcase
        if (phase_r == 2'd2) begin
          state_nxt = imsv_pkg::ST_OUT;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = imsv_pkg::ST_SX;
        end
      end
      imsv_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = imsv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = imsv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= imsv_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      angle_r <= 32'd0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      angle_r <= angle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    rec_r <= rec_nxt;
    slip_r <= slip_nxt;
    inc_r <= inc_nxt;
    amp_r <= amp_nxt;
    phase_r <= phase_nxt;
    neg_r <= neg_nxt;
    s_r <= s_nxt;
    t_r <= t_nxt;
    x2_r <= x2_nxt;
    n_r <= n_nxt;
    q0_r <= q0_nxt;
    step_r <= step_nxt;
    duty_a_r <= duty_a_nxt;
    duty_b_r <= duty_b_nxt;
    duty_c_r <= duty_c_nxt;
    if (out_load) begin
      o_duty_a_r <= duty_a_r;
      o_duty_b_r <= duty_b_r;
      o_duty_c_r <= duty_c_r;
      o_amp_r <= amp_r;
      o_speed_r <= rec_r.diff;
      o_oe_r <= rec_r.oe;
      o_fault_r <= rec_r.fault;
    end
  end

  assign out_valid = out_valid_r;
  assign out_duty_a = o_duty_a_r;
  assign out_duty_b = o_duty_b_r;
  assign out_duty_c = o_duty_c_r;
  assign out_amplitude = o_amp_r;
  assign out_speed_delta = o_speed_r;
  assign out_output_enable = o_oe_r;
  assign out_fault = o_fault_r;

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == imsv_pkg::ST_DF) |-> (rem_w < {24'd0, k_w, 1'b0}))
    else $error("reciprocal quotient off by more than one");

  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == imsv_pkg::ST_SLIP))
    else $error("popped record not started");

  a_amp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (($signed(out_amplitude) <= $signed({1'b0, cfg.voltage_limit})) &&
                  ($signed(out_amplitude) >= -$signed({1'b0, cfg.voltage_limit}))))
    else $error("amplitude beyond voltage limit");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == imsv_pkg::ST_DT) |-> (phase_r != 2'd3))
    else $error("phase counter overran");
`endif

endmodule

`default_nettype wire

// File: rtl/induction_motor_slip_vf_step_core.sv
// ----------------------------------------------------------------------------
// induction_motor_slip_vf_step_core
// Volts-per-hertz induction motor drive step with slip control: one request
// per PWM tick in, three phase duties, amplitude, speed and status out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : request channel (encoder count, throttle sample, forward, start).
//   out_*  : result channel, exactly one result per request, in order.
//   cfg_*  : register writes (index 0..6), always ready; write only when idle.
// Structure:
//   The front stage registers requests and hands records to a two-entry queue.
//   The back part runs each request through one shared 33x33 multiplier in
//   sequence: slip, increment and amplitude, then for each phase a 5-term sine
//   series with reciprocal-multiply divides and the duty product. The front
//   stage and queue can take new requests while the back part is busy with an
//   earlier one; the back part works on one request at a time.
// Reset:
//   Synchronous, active low. Clears the encoder history (per-entry valid
//   bits), stator angle and fault latch, and loads register defaults.
// Stall:
//   Results wait in the output register; the queue then fills and in_ready
//   drops until out_ready takes the waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

module induction_motor_slip_vf_step_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        in_encoder_count,
  input  wire logic [11:0]        in_throttle_adc,
  input  wire logic               in_forward,
  input  wire logic               in_start_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [11:0]             out_duty_a,
  output logic [11:0]             out_duty_b,
  output logic [11:0]             out_duty_c,
  output logic signed [11:0]      out_amplitude,
  output logic signed [15:0]      out_speed_delta,
  output logic                    out_output_enable,
  output logic                    out_fault,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  imsv_pkg::cfg_t cfg_r;
  imsv_pkg::rec_t push_rec;
  imsv_pkg::rec_t pop_rec;
  logic           push;
  logic           push_ready;
  logic           pop_valid;
  logic           pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_min <= 12'd100;
      cfg_r.throttle_max <= 12'd4000;
      cfg_r.slip_gain <= 32'd20620876;
      cfg_r.encoder_gain <= 24'd233016;
      cfg_r.volt_gain <= 24'd188125;
      cfg_r.voltage_limit <= 11'd1935;
      cfg_r.overspeed_limit <= 15'd400;
    end else if (cfg_valid && cfg_ready) begin
      case (imsv_pkg::cfg_reg_t'(cfg_index))
        imsv_pkg::CFG_THROTTLE_MIN:    cfg_r.throttle_min <= cfg_data[11:0];
        imsv_pkg::CFG_THROTTLE_MAX:    cfg_r.throttle_max <= cfg_data[11:0];
        imsv_pkg::CFG_SLIP_GAIN:       cfg_r.slip_gain <= cfg_data;
        imsv_pkg::CFG_ENCODER_GAIN:    cfg_r.encoder_gain <= cfg_data[23:0];
        imsv_pkg::CFG_VOLT_GAIN:       cfg_r.volt_gain <= cfg_data[23:0];
        imsv_pkg::CFG_VOLTAGE_LIMIT:   cfg_r.voltage_limit <= cfg_data[10:0];
        imsv_pkg::CFG_OVERSPEED_LIMIT: cfg_r.overspeed_limit <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  imsv_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_encoder_count (in_encoder_count),
    .in_throttle_adc  (in_throttle_adc),
    .in_forward       (in_forward),
    .in_start_req     (in_start_req),
    .q_push           (push),
    .q_ready          (push_ready),
    .q_rec            (push_rec)
  );

  imsv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_rec    (pop_rec)
  );

  imsv_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (pop_valid),
    .q_pop             (pop),
    .q_rec             (pop_rec),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_duty_a        (out_duty_a),
    .out_duty_b        (out_duty_b),
    .out_duty_c        (out_duty_c),
    .out_amplitude     (out_amplitude),
    .out_speed_delta   (out_speed_delta),
    .out_output_enable (out_output_enable),
    .out_fault         (out_fault)
  );

endmodule

`default_nettype wire

// File: tb/induction_motor_slip_vf_step_core_test.sv
// ----------------------------------------------------------------------------
// induction_motor_slip_vf_step_core_test
// Self-checking bench for the slip-control volts-per-hertz step core. A short
// table of directed requests runs under the reset register values. Random
// phases follow, each under its own register setting. Encoder counts mostly
// follow a drifting speed so that the history ring sees realistic deltas.
// Requests without a table result are predicted by an in-bench drive model:
// speed ring, slip, stator angle, amplitude, fault latch and a locally built
// sine table. Results are checked field by field, in order, against both.
// Both handshakes idle at random in some phases, and the result side holds
// off for a long stretch once so that the core fills up and stalls its input.
// ----------------------------------------------------------------------------
module induction_motor_slip_vf_step_core_test;

  localparam int RING_LEN = 256;
  localparam int ANG_SH = 19;
  localparam int LUT_LEN = 1 << (32 - ANG_SH);
  localparam int QTR_LEN = LUT_LEN / 4;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam logic [11:0] MIDPOINT = 12'd2047;
  localparam int HOLD_LEN = 600;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE = 100;
  localparam int NDIR = 15;
  localparam int MAX_LINES = 50;

  typedef struct packed {
    logic [15:0] enc;
    logic [11:0] thr;
    logic        fwd;
    logic        start;
  } tick_t;

  typedef struct packed {
    logic [11:0]        duty_a;
    logic [11:0]        duty_b;
    logic [11:0]        duty_c;
    logic signed [11:0] amplitude;
    logic [15:0]        speed_delta;
    logic               oe;
    logic               fault;
  } drive_t;

  typedef struct packed {
    tick_t  tick;
    logic   known;
    drive_t res;
  } row_t;

  localparam drive_t NO_DRIVE = '0;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [15:0] in_encoder_count = '0;
  logic [11:0] in_throttle_adc = '0;
  logic in_forward = 1'b0;
  logic in_start_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] out_duty_a;
  logic [11:0] out_duty_b;
  logic [11:0] out_duty_c;
  logic signed [11:0] out_amplitude;
  logic signed [15:0] out_speed_delta;
  logic out_output_enable;
  logic out_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  imsv_pkg::cfg_reg_t cfg_index = imsv_pkg::CFG_THROTTLE_MIN;
  logic [31:0] cfg_data = '0;

  // drive model state
  logic signed [15:0] sine_lut [LUT_LEN];
  logic [15:0] drv_hist [RING_LEN];
  logic [7:0] drv_pos;
  logic [31:0] drv_angle;
  logic drv_fault;
  imsv_pkg::cfg_t drv_cfg;

  drive_t drive_q [$];
  int err_count = 0;
  int rx_count = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  logic pressure_go = 1'b0;

  logic [15:0] enc_run = '0;
  int enc_frac = 0;
  int enc_rate = 0;
  int tick_seq = 0;

  induction_motor_slip_vf_step_core u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_encoder_count(in_encoder_count),
    .in_throttle_adc(in_throttle_adc),
    .in_forward(in_forward),
    .in_start_req(in_start_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_duty_a(out_duty_a),
    .out_duty_b(out_duty_b),
    .out_duty_c(out_duty_c),
    .out_amplitude(out_amplitude),
    .out_speed_delta(out_speed_delta),
    .out_output_enable(out_output_enable),
    .out_fault(out_fault),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int quarter_wave(int unsigned r);
    longint unsigned x, x2, t, v;
    longint s;
    x = 64'(r) * PI_HALF_Q30 / 64'(QTR_LEN);
    x2 = (x * x) >> 30;
    t = x;
    s = longint'(x);
    t = ((t * x2) >> 30) / 6;
    s -= longint'(t);
    t = ((t * x2) >> 30) / 20;
    s += longint'(t);
    t = ((t * x2) >> 30) / 42;
    s -= longint'(t);
    t = ((t * x2) >> 30) / 72;
    s += longint'(t);
    if (s < 0) s = 0;
    v = (64'(s) + (64'd1 << 14)) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return int'(v);
  endfunction

  function automatic logic [11:0] phase_duty(int amp, logic [31:0] ang);
    int s, p, mag, term;
    s = sine_lut[ang >> ANG_SH];
    p = amp * s;
    mag = (p < 0 ? -p : p) >> 15;
    term = (p < 0) ? -mag : mag;
    return 12'(int'(MIDPOINT) + term);
  endfunction

  function automatic drive_t advance_drive(tick_t t);
    drive_t d;
    logic [15:0] diff;
    int delta, braked, lim, amp;
    int unsigned thr, off;
    longint slip, wide, inc, prod;
    longint unsigned amag;
    logic [31:0] inc_u;
    diff = t.enc - drv_hist[drv_pos];
    delta = int'($signed(diff));
    braked = (delta > 0) ? delta - 1 : ((delta < 0) ? delta + 1 : 0);
    drv_hist[drv_pos] = t.enc;
    drv_pos = drv_pos + 8'd1;

    thr = t.thr;
    if (thr < drv_cfg.throttle_min) thr = drv_cfg.throttle_min;
    if (thr > drv_cfg.throttle_max) thr = drv_cfg.throttle_max;
    off = (thr >= drv_cfg.throttle_min) ? thr - drv_cfg.throttle_min : 0;
    slip = t.fwd ? longint'((64'(off) * 64'(drv_cfg.slip_gain)) >> 16) : 0;

    wide = longint'(braked) * longint'(drv_cfg.encoder_gain) + slip;
    inc_u = wide[31:0];
    inc = longint'($signed(inc_u));
    drv_angle = drv_angle + inc_u;

    lim = int'(drv_cfg.overspeed_limit);
    if (delta > lim || delta < -lim) drv_fault = 1'b1;

    prod = inc * longint'(drv_cfg.volt_gain);
    amag = 64'(prod < 0 ? -prod : prod) >> 32;
    if (amag > 64'(drv_cfg.voltage_limit)) amag = 64'(drv_cfg.voltage_limit);
    amp = (prod < 0) ? -int'(amag) : int'(amag);

    d.duty_a = phase_duty(amp, drv_angle);
    d.duty_b = phase_duty(amp, drv_angle + 32'h5555_5555);
    d.duty_c = phase_duty(amp, drv_angle + 32'hAAAA_AAAB);
    d.amplitude = 12'(amp);
    d.speed_delta = diff;
    d.oe = t.start && !drv_fault;
    d.fault = drv_fault;
    return d;
  endfunction

  function automatic drive_t quiet(logic [15:0] spd, logic oe);
    return '{MIDPOINT, MIDPOINT, MIDPOINT, 12'sd0, spd, oe, 1'b0};
  endfunction

  // directed requests under reset registers; history still all zero
  function automatic row_t dir_row(int k);
    case (k)
      0:  return '{'{16'h0000, 12'd0,    1'b0, 1'b0}, 1'b1, quiet(16'h0000, 1'b0)};
      1:  return '{'{16'h0000, 12'd0,    1'b0, 1'b1}, 1'b1, quiet(16'h0000, 1'b1)};
      2:  return '{'{16'hFFFF, 12'd0,    1'b1, 1'b1}, 1'b1, quiet(16'hFFFF, 1'b1)};
      3:  return '{'{16'h0001, 12'd100,  1'b1, 1'b1}, 1'b1, quiet(16'h0001, 1'b1)};
      4:  return '{'{16'h0000, 12'hFFF,  1'b0, 1'b1}, 1'b1, quiet(16'h0000, 1'b1)};
      5:  return '{'{16'h0000, 12'hFFF,  1'b1, 1'b1}, 1'b0, NO_DRIVE};
      6:  return '{'{16'h0000, 12'd4000, 1'b1, 1'b0}, 1'b0, NO_DRIVE};
      7:  return '{'{16'h0000, 12'd4001, 1'b1, 1'b1}, 1'b0, NO_DRIVE};
      8:  return '{'{16'h0000, 12'd99,   1'b1, 1'b1}, 1'b1, quiet(16'h0000, 1'b1)};
      9:  return '{'{16'h0000, 12'd101,  1'b1, 1'b1}, 1'b0, NO_DRIVE};
      10: return '{'{16'h0002, 12'd0,    1'b0, 1'b1}, 1'b0, NO_DRIVE};
      11: return '{'{16'h0190, 12'd2048, 1'b1, 1'b1}, 1'b0, NO_DRIVE};
      12: return '{'{16'hFE70, 12'd2048, 1'b1, 1'b1}, 1'b0, NO_DRIVE};
      13: return '{'{16'h00C8, 12'd3000, 1'b1, 1'b0}, 1'b0, NO_DRIVE};
      default: return '{'{16'hFF38, 12'd555, 1'b0, 1'b1}, 1'b0, NO_DRIVE};
    endcase
  endfunction

  function automatic tick_t make_tick();
    tick_t t;
    int stride, roll;
    logic [15:0] span;
    if (tick_seq % 64 == 0) begin
      if ($urandom_range(99) < 70) enc_rate = int'($urandom_range(1200)) - 600;
      else enc_rate = int'($urandom_range(64000)) - 32000;
    end
    tick_seq++;
    enc_frac += enc_rate + int'($urandom_range(64)) - 32;
    stride = enc_frac >>> 8;
    enc_frac -= stride * 256;
    enc_run = enc_run + 16'(stride);
    t.enc = ($urandom_range(99) < 15) ? 16'($urandom) : enc_run;
    // keep the fault clear while the limit is at its top
    span = t.enc - drv_hist[drv_pos];
    if (drv_cfg.overspeed_limit == 15'h7FFF && span == 16'h8000) t.enc[0] = ~t.enc[0];
    roll = $urandom_range(99);
    if (roll < 8) t.thr = 12'd0;
    else if (roll < 16) t.thr = 12'hFFF;
    else if (roll < 28) t.thr = drv_cfg.throttle_min + 12'($urandom_range(2)) - 12'd1;
    else if (roll < 36) t.thr = drv_cfg.throttle_max + 12'($urandom_range(2)) - 12'd1;
    else t.thr = 12'($urandom_range(4095));
    t.fwd = ($urandom_range(99) < 80);
    t.start = ($urandom_range(99) < 85);
    return t;
  endfunction

  function automatic imsv_pkg::cfg_t rand_cfg();
    imsv_pkg::cfg_t c;
    c.throttle_min = 12'($urandom_range(1500));
    c.throttle_max = 12'($urandom_range(4095, 1000));
    c.slip_gain = $urandom;
    c.encoder_gain = ($urandom_range(1) != 0) ? 24'($urandom_range(400000)) : 24'($urandom);
    c.volt_gain = ($urandom_range(1) != 0) ? 24'($urandom_range(400000)) : 24'($urandom);
    c.voltage_limit = 11'($urandom_range(2047));
    c.overspeed_limit = 15'h7FFF;
    return c;
  endfunction

  function automatic logic [31:0] reg_word(imsv_pkg::cfg_t c, imsv_pkg::cfg_reg_t r);
    case (r)
      imsv_pkg::CFG_THROTTLE_MIN:    return 32'(c.throttle_min);
      imsv_pkg::CFG_THROTTLE_MAX:    return 32'(c.throttle_max);
      imsv_pkg::CFG_SLIP_GAIN:       return c.slip_gain;
      imsv_pkg::CFG_ENCODER_GAIN:    return 32'(c.encoder_gain);
      imsv_pkg::CFG_VOLT_GAIN:       return 32'(c.volt_gain);
      imsv_pkg::CFG_VOLTAGE_LIMIT:   return 32'(c.voltage_limit);
      imsv_pkg::CFG_OVERSPEED_LIMIT: return 32'(c.overspeed_limit);
      default:                       return '0;
    endcase
  endfunction

  task automatic program_regs(input imsv_pkg::cfg_t c);
    for (int k = int'(imsv_pkg::CFG_THROTTLE_MIN); k <= int'(imsv_pkg::CFG_OVERSPEED_LIMIT);
         k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= imsv_pkg::cfg_reg_t'(k);
      cfg_data <= reg_word(c, imsv_pkg::cfg_reg_t'(k));
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    drv_cfg = c;
  endtask

  task automatic issue_tick(input row_t r);
    drive_t d;
    d = advance_drive(r.tick);
    drive_q.push_back(r.known ? r.res : d);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_encoder_count <= r.tick.enc;
    in_throttle_adc <= r.tick.thr;
    in_forward <= r.tick.fwd;
    in_start_req <= r.tick.start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic finish_batch();
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input imsv_pkg::cfg_t c, input int n);
    program_regs(c);
    for (int i = 0; i < n; i++) issue_tick('{make_tick(), 1'b0, NO_DRIVE});
    finish_batch();
  endtask

  task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_LINES)
      $display("mismatch at result %0d: %s got %0h want %0h", rx_count, what, got, want);
  endtask

  task automatic check_drive(input drive_t w);
    drive_t g;
    g = '{out_duty_a, out_duty_b, out_duty_c, out_amplitude, out_speed_delta,
          out_output_enable, out_fault};
    if (g.duty_a !== w.duty_a) flag("duty_a", 32'(g.duty_a), 32'(w.duty_a));
    if (g.duty_b !== w.duty_b) flag("duty_b", 32'(g.duty_b), 32'(w.duty_b));
    if (g.duty_c !== w.duty_c) flag("duty_c", 32'(g.duty_c), 32'(w.duty_c));
    if (g.amplitude !== w.amplitude) flag("amplitude", 32'(g.amplitude), 32'(w.amplitude));
    if (g.speed_delta !== w.speed_delta)
      flag("speed_delta", 32'(g.speed_delta), 32'(w.speed_delta));
    if (g.oe !== w.oe) flag("output_enable", 32'(g.oe), 32'(w.oe));
    if (g.fault !== w.fault) flag("fault", 32'(g.fault), 32'(w.fault));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (drive_q.size() == 0) flag("result with no request pending", 32'd1, 32'd0);
      else check_drive(drive_q.pop_front());
      rx_count++;
    end
  end

  initial begin : result_side
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (pressure_go && held < HOLD_LEN) begin
        out_ready <= 1'b0;
        held++;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    imsv_pkg::cfg_t c;
    for (int i = 0; i < LUT_LEN; i++) begin
      int q, r, v;
      q = i / QTR_LEN;
      r = i % QTR_LEN;
      v = (q % 2 == 1) ? quarter_wave(QTR_LEN - r) : quarter_wave(r);
      sine_lut[i] = 16'((q / 2 == 1) ? -v : v);
    end
    for (int i = 0; i < RING_LEN; i++) drv_hist[i] = '0;
    drv_pos = '0;
    drv_angle = '0;
    drv_fault = 1'b0;
    drv_cfg = '{12'd100, 12'd4000, 32'd20620876, 24'd233016, 24'd188125, 11'd1935, 15'd400};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle = 21;
    rx_idle = 50;
    for (int k = 0; k < NDIR; k++) issue_tick(dir_row(k));
    finish_batch();

    run_phase('{12'd0, 12'd4095, 32'd20620876, 24'd233016, 24'd188125, 11'd2047,
                15'h7FFF}, 500);

    tx_idle = 50;
    rx_idle = 21;
    // min above max: offset collapses to zero
    run_phase('{12'd4095, 12'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 11'd2047,
                15'h7FFF}, 200);
    run_phase('{12'd0, 12'd4095, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'd4096, 11'd1000,
                15'h7FFF}, 300);

    tx_idle = 0;
    rx_idle = 0;
    pressure_go <= 1'b1;
    run_phase(rand_cfg(), 300);
    run_phase(rand_cfg(), 200);

    // let the overspeed fault latch
    c = rand_cfg();
    c.overspeed_limit = 15'($urandom_range(8000, 1000));
    run_phase(c, 150);
    c.slip_gain = '0;
    c.encoder_gain = '0;
    c.volt_gain = '0;
    c.voltage_limit = '0;
    c.overspeed_limit = '0;
    run_phase(c, 100);

    repeat (SETTLE) @(posedge clk);
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
rtl/imsv_pkg.sv
rtl/imsv_front.sv
rtl/imsv_queue.sv
rtl/imsv_back.sv
rtl/induction_motor_slip_vf_step_core.sv
tb/induction_motor_slip_vf_step_core_test.sv
